### rtl/lrwe_pkg.sv
// Shared types and constants for the link receive watchdog escalation unit.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lrwe_pkg;

    localparam int unsigned TimerW    = 16;
    localparam int unsigned CountW    = 16;
    localparam int unsigned ThreshW   = 8;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 16;

    localparam logic [TimerW-1:0]  SilenceIntervalRst  = TimerW'(90);
    localparam logic [ThreshW-1:0] RestartThresholdRst = ThreshW'(2);
    localparam logic [ThreshW-1:0] FailedThresholdRst  = ThreshW'(4);

    localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    // Event kinds
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_FRAME   = 2'd1,
        FUNC_OUTCOME = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        CFG_SILENCE_INTERVAL  = 2'd0,
        CFG_RESTART_THRESHOLD = 2'd1,
        CFG_FAILED_THRESHOLD  = 2'd2,
        CFG_UNUSED            = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TIMEOUT    = 3'd1,
        ST_RESTARTING = 3'd2,
        ST_RECOVERING = 3'd3,
        ST_FAILED     = 3'd4
    } link_state_t;

    typedef struct packed {
        logic [1:0] func;
        logic       restart_ok;
    } lrwe_in_t;

    typedef struct packed {
        logic [2:0]        link_state;
        logic [CountW-1:0] timeouts_seen;
        logic              restart_request;
    } lrwe_out_t;

    typedef struct packed {
        logic [TimerW-1:0]  silence_interval;
        logic [ThreshW-1:0] restart_threshold;
        logic [ThreshW-1:0] failed_threshold;
    } lrwe_cfg_t;

endpackage

`default_nettype wire

### rtl/lrwe_in_stage.sv
// Input register of the watchdog: one item held between the s_ channel and
// the update logic. Depends on lrwe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrwe_in_stage
    import lrwe_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire lrwe_in_t s_data,
    output logic          item_valid,
    output lrwe_in_t      item,
    input  wire logic     item_take
);

    logic     valid_reg;
    logic     valid_next;
    lrwe_in_t item_reg;

    // Refill in the same cycle the held item moves on
    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### rtl/lrwe_update.sv
// Watchdog state (silence timer, timeout count, link state) and the one-step
// update applied per item. Depends on lrwe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrwe_update
    import lrwe_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire lrwe_cfg_t cfg,
    input  wire logic      advance,
    input  wire lrwe_in_t  item,
    output lrwe_out_t      result
);

    logic [TimerW-1:0] timer_reg;
    logic [TimerW-1:0] timer_next;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;
    link_state_t       state_reg;
    link_state_t       state_next;

    logic [TimerW-1:0] timer_inc;
    logic [CountW-1:0] count_inc;
    link_state_t       timeout_state;

    always_comb begin
        timer_inc = (timer_reg != TimerMax) ? timer_reg + TimerW'(1) : timer_reg;
        count_inc = (count_reg != CountMax) ? count_reg + CountW'(1) : count_reg;

        // Failed test first, then restart
        if (count_inc >= CountW'(cfg.failed_threshold)) begin
            timeout_state = ST_FAILED;
        end else if (count_inc >= CountW'(cfg.restart_threshold)) begin
            timeout_state = ST_RESTARTING;
        end else begin
            timeout_state = ST_TIMEOUT;
        end

        timer_next = timer_reg;
        count_next = count_reg;
        state_next = state_reg;

        unique case (func_t'(item.func))
            FUNC_TICK: begin
                if (timer_inc >= cfg.silence_interval) begin
                    timer_next = '0;
                    count_next = count_inc;
                    state_next = timeout_state;
                end else begin
                    timer_next = timer_inc;
                end
            end
            FUNC_FRAME: begin
                timer_next = '0;
                count_next = '0;
                state_next = ST_OK;
            end
            FUNC_OUTCOME: begin
                if (state_reg == ST_RESTARTING) begin
                    if (item.restart_ok) begin
                        timer_next = '0;
                        state_next = ST_RECOVERING;
                    end else begin
                        state_next = ST_FAILED;
                    end
                end
            end
            default: begin
            end
        endcase

        result.link_state      = state_next;
        result.timeouts_seen   = count_next;
        result.restart_request = (state_next == ST_RESTARTING);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            count_reg <= '0;
            state_reg <= ST_OK;
        end else if (advance) begin
            timer_reg <= timer_next;
            count_reg <= count_next;
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/link_rx_watchdog_escalation_unit.sv
// Top level of the link receive watchdog: configuration registers, input
// register, state update and result register. Depends on lrwe_pkg,
// lrwe_in_stage and lrwe_update.
`timescale 1ns / 1ps
`default_nettype none

// Receive-silence watchdog with escalating recovery. Each item on the s_
// channel is one event (func 0 one-second tick, 1 frame received, 2 restart
// outcome with restart_ok, 3 no effect) and yields exactly one result item on
// the m_ channel: the link state after the event, the consecutive timeout
// count (saturating at 65535) and a restart request flag that is high while
// the state is RESTARTING. Items flow at one per clock as long as m_ready
// keeps up: an item is held in the input register, the state update consumes
// it when it advances, and the result is captured in the output register in
// the same edge. The result register stalls the pipe only while a result
// waits and m_ready is low. Configuration (index 0 silence interval, 1 restart
// threshold, 2 failed threshold) is written through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while the unit is idle, which the block itself
// does not enforce. Writes to index 3 are dropped. Reset restores 90/2/4,
// clears the timer and the count and puts the link in OK.
module link_rx_watchdog_escalation_unit
    import lrwe_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CfgIndexW-1:0] cfg_index,
    input  wire logic [CfgDataW-1:0]  cfg_wdata,
    // event items in
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire lrwe_in_t             s_data,
    // result items out
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output lrwe_out_t                 m_data
);

    lrwe_cfg_t cfg_reg;

    logic      item_valid;
    lrwe_in_t  item;
    logic      advance;
    lrwe_out_t result;

    logic      m_valid_reg;
    logic      m_valid_next;
    lrwe_out_t m_data_reg;

    // Hold the configuration; unused index is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.silence_interval  <= SilenceIntervalRst;
            cfg_reg.restart_threshold <= RestartThresholdRst;
            cfg_reg.failed_threshold  <= FailedThresholdRst;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SILENCE_INTERVAL:  cfg_reg.silence_interval  <= cfg_wdata[TimerW-1:0];
                CFG_RESTART_THRESHOLD: cfg_reg.restart_threshold <= cfg_wdata[ThreshW-1:0];
                CFG_FAILED_THRESHOLD:  cfg_reg.failed_threshold  <= cfg_wdata[ThreshW-1:0];
                default: begin
                end
            endcase
        end
    end

    lrwe_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (advance)
    );

    // Advance the held item when the result register is free or draining
    assign advance = item_valid && (!m_valid_reg || m_ready);

    lrwe_update u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    assign m_valid_next = advance || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

### tb/link_status_tracker_pkg.sv
// Expected-result tracker for the link receive watchdog testbench.
// Depends on lrwe_pkg for the item, result and register index types.
`timescale 1ns / 1ps

package link_status_tracker_pkg;
    import lrwe_pkg::*;

    class link_status_tracker;
        // register copies, at their reset values
        logic [TimerW-1:0]  interval_reg = SilenceIntervalRst;
        logic [ThreshW-1:0] restart_reg  = RestartThresholdRst;
        logic [ThreshW-1:0] failed_reg   = FailedThresholdRst;

        // watchdog state
        logic [TimerW-1:0] timer  = '0;
        logic [CountW-1:0] count  = '0;
        link_state_t       status = ST_OK;

        lrwe_out_t   reports_due[$];
        int unsigned errors  = 0;
        int unsigned checked = 0;

        function void set_register(cfg_index_t idx, logic [CfgDataW-1:0] value);
            case (idx)
                CFG_SILENCE_INTERVAL:  interval_reg = value;
                CFG_RESTART_THRESHOLD: restart_reg  = value[ThreshW-1:0];
                CFG_FAILED_THRESHOLD:  failed_reg   = value[ThreshW-1:0];
                default: ;
            endcase
        endfunction

        // Advance the state by one accepted item and queue the result it causes.
        function void note_event(lrwe_in_t ev);
            lrwe_out_t res;
            case (func_t'(ev.func))
                FUNC_TICK: begin
                    if (timer != TimerMax) timer++;
                    if (timer >= interval_reg) begin
                        timer = '0;
                        if (count != CountMax) count++;
                        // failed test first, so inverted thresholds go straight to failed
                        if (count >= failed_reg)       status = ST_FAILED;
                        else if (count >= restart_reg) status = ST_RESTARTING;
                        else                           status = ST_TIMEOUT;
                    end
                end
                FUNC_FRAME: begin
                    timer  = '0;
                    count  = '0;
                    status = ST_OK;
                end
                FUNC_OUTCOME: begin
                    if (status == ST_RESTARTING) begin
                        if (ev.restart_ok) begin
                            timer  = '0;
                            status = ST_RECOVERING;
                        end else begin
                            status = ST_FAILED;
                        end
                    end
                end
                default: ;
            endcase
            res.link_state      = status;
            res.timeouts_seen   = count;
            res.restart_request = (status == ST_RESTARTING);
            reports_due.push_back(res);
        endfunction

        function void check_report(lrwe_out_t got);
            lrwe_out_t want;
            if (reports_due.size() == 0) begin
                $error("result item with none outstanding: state %0d count %0d",
                       got.link_state, got.timeouts_seen);
                errors++;
                return;
            end
            want = reports_due.pop_front();
            checked++;
            if (got.link_state !== want.link_state) begin
                $error("link_state: expected %0d, got %0d", want.link_state, got.link_state);
                errors++;
            end
            if (got.timeouts_seen !== want.timeouts_seen) begin
                $error("timeouts_seen: expected %0d, got %0d",
                       want.timeouts_seen, got.timeouts_seen);
                errors++;
            end
            if (got.restart_request !== want.restart_request) begin
                $error("restart_request: expected %0d, got %0d",
                       want.restart_request, got.restart_request);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return reports_due.size();
        endfunction
    endclass

endpackage

### tb/tb_link_rx_watchdog_escalation_unit.sv
// Top-level testbench for link_rx_watchdog_escalation_unit: clock, reset,
// item and register drivers, result checking. Depends on lrwe_pkg and
// link_status_tracker_pkg.
`timescale 1ns / 1ps

module tb_link_rx_watchdog_escalation_unit;
    import lrwe_pkg::*;
    import link_status_tracker_pkg::*;

    localparam int unsigned CycleLimit = 1_000_000;
    localparam int unsigned RandomRounds = 6;
    localparam int unsigned ItemsPerRound = 120;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = CFG_SILENCE_INTERVAL;
    logic [CfgDataW-1:0]  cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    lrwe_in_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    lrwe_out_t            m_data;

    link_status_tracker trk;

    int unsigned src_idle_pct   = 0;
    int unsigned dst_idle_pct   = 0;
    int unsigned frame_permille = 20;
    int unsigned items_sent     = 0;
    int unsigned settings_made  = 0;
    int unsigned cycles         = 0;

    link_rx_watchdog_escalation_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // Bound the run: a hang in either handshake ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, trk.pending());
            $display("FAIL link_rx_watchdog_escalation_unit");
            $finish;
        end
    end

    // Result side: check every accepted result, then draw the next ready.
    // Values read here are the ones from before this edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            trk.check_report(m_data);
        m_ready <= aresetn && ($urandom_range(99) >= dst_idle_pct);
    end

    // Select one of the three idling patterns: sender light and receiver
    // heavy, then the reverse, then no idling at all.
    function automatic void set_idling(input int unsigned pattern);
        case (pattern)
            0: begin src_idle_pct = 15; dst_idle_pct = 46; end
            1: begin src_idle_pct = 46; dst_idle_pct = 15; end
            default: begin src_idle_pct = 0; dst_idle_pct = 0; end
        endcase
    endfunction

    // Offer one item, hold it until accepted, then maybe idle a few cycles.
    // Valid is lowered only when an idle gap follows, so back-to-back items
    // never see valid drop and rise within one step.
    task automatic push_event(input func_t kind, input logic ok);
        lrwe_in_t ev;
        ev.func       = kind;
        ev.restart_ok = ok;
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        trk.note_event(ev);
        items_sent++;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
    endtask

    task automatic push_run(input func_t kind, input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            push_event(kind, 1'($urandom_range(1)));
    endtask

    // Leave cfg_we high; the caller drops it after the last write of a group.
    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        trk.set_register(idx, value);
    endtask

    task automatic apply_settings(input logic [TimerW-1:0] interval,
                                  input logic [ThreshW-1:0] restart_at,
                                  input logic [ThreshW-1:0] failed_at);
        write_reg(CFG_SILENCE_INTERVAL, interval);
        write_reg(CFG_RESTART_THRESHOLD, CfgDataW'(restart_at));
        write_reg(CFG_FAILED_THRESHOLD, CfgDataW'(failed_at));
        cfg_we <= 1'b0;
        settings_made++;
    endtask

    // Drop valid and wait until every result is back, plus the pipe depth.
    task automatic settle();
        s_valid <= 1'b0;
        while (trk.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly well-formed escalation: ticks with rare frames so the count
    // climbs through timeout, restarting and failed; answer a restart
    // request half the time; sprinkle unused kinds and stray outcomes.
    function automatic func_t pick_kind();
        int unsigned roll;
        roll = $urandom_range(999);
        if (trk.status == ST_RESTARTING && roll < 500) return FUNC_OUTCOME;
        if (roll < 30)                   return FUNC_NONE;
        if (roll < 60)                   return FUNC_OUTCOME;
        if (roll < 60 + frame_permille)  return FUNC_FRAME;
        return FUNC_TICK;
    endfunction

    initial begin
        logic [TimerW-1:0]  interval;
        logic [ThreshW-1:0] restart_at;
        logic [ThreshW-1:0] failed_at;

        trk = new();

        // Hold reset, then release it once.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings (90 / 2 / 4): stray kinds first, then climb the ladder.
        set_idling(0);
        push_event(FUNC_NONE, 1'b1);
        push_event(FUNC_OUTCOME, 1'b1);
        push_event(FUNC_OUTCOME, 1'b0);
        push_event(FUNC_FRAME, 1'b1);
        push_run(FUNC_TICK, 90);
        push_run(FUNC_TICK, 90);
        push_event(FUNC_OUTCOME, 1'b0);
        push_event(FUNC_FRAME, 1'b0);
        push_run(FUNC_TICK, 180);
        push_event(FUNC_OUTCOME, 1'b1);
        push_event(FUNC_OUTCOME, 1'b1);
        push_run(FUNC_TICK, 180);
        push_event(FUNC_NONE, 1'b0);
        settle();

        // Zero interval and zero thresholds: every tick times out and fails.
        apply_settings(16'd0, 8'd0, 8'd0);
        push_run(FUNC_TICK, 3);
        push_event(FUNC_FRAME, 1'b1);
        push_event(FUNC_TICK, 1'b0);
        settle();

        // Poke the unused register index, which must change nothing; then
        // zero restart threshold, maximal failed threshold: restart at once.
        write_reg(CFG_UNUSED, 16'hFFFF);
        apply_settings(16'd0, 8'd0, 8'd255);
        push_run(FUNC_TICK, 2);
        push_event(FUNC_OUTCOME, 1'b1);
        push_event(FUNC_TICK, 1'b1);
        push_event(FUNC_OUTCOME, 1'b0);
        settle();

        // Inverted thresholds: failed is tested first and wins.
        apply_settings(16'd1, 8'd10, 8'd3);
        push_event(FUNC_FRAME, 1'b0);
        push_run(FUNC_TICK, 4);
        settle();

        // Lower the interval below a running timer: next tick times out.
        apply_settings(16'd50, 8'd2, 8'd4);
        push_event(FUNC_FRAME, 1'b0);
        push_run(FUNC_TICK, 30);
        settle();
        write_reg(CFG_SILENCE_INTERVAL, 16'd5);
        cfg_we <= 1'b0;
        push_run(FUNC_TICK, 2);
        settle();

        // Longest interval with both thresholds at their top: no timeout.
        apply_settings(16'hFFFF, 8'd255, 8'd255);
        push_event(FUNC_FRAME, 1'b1);
        push_run(FUNC_TICK, 20);
        settle();

        // One timeout per tick: the count runs past the top failed threshold.
        apply_settings(16'd1, 8'd1, 8'd255);
        push_event(FUNC_FRAME, 1'b0);
        push_run(FUNC_TICK, 300);
        push_event(FUNC_OUTCOME, 1'b1);
        push_event(FUNC_FRAME, 1'b1);
        settle();

        // Random rounds: small settings so escalation happens often, two
        // rounds per idling pattern, register writes only between rounds.
        for (int unsigned r = 0; r < RandomRounds; r++) begin
            set_idling(r / 2);
            interval   = ($urandom_range(9) == 0) ? 16'd0 : TimerW'($urandom_range(1, 8));
            restart_at = ThreshW'($urandom_range(0, 6));
            failed_at  = ThreshW'($urandom_range(0, 8));
            apply_settings(interval, restart_at, failed_at);
            frame_permille = 600 / (int'(interval) * int'(failed_at) + 1) + 8;
            for (int unsigned n = 0; n < ItemsPerRound; n++)
                push_event(pick_kind(), 1'($urandom_range(1)));
            settle();
        end

        $display("%0d event items sent, %0d results checked, %0d register settings",
                 items_sent, trk.checked, settings_made);
        $display("covered: escalation ladder, zero/inverted/max thresholds, "
                 , "interval lowered under timer, count past threshold, three idling mixes");
        if (trk.errors == 0) begin
            $display("PASS link_rx_watchdog_escalation_unit");
        end else begin
            $display("%0d mismatches", trk.errors);
            $display("FAIL link_rx_watchdog_escalation_unit");
        end
        $finish;
    end

endmodule
